[hw/rtl/elcb_pkg.sv]
package elcb_pkg;

  localparam int VERTEX_W = 11;
  localparam int INDEX_W  = 13;
  localparam int STATUS_W = 3;
  localparam int VALUE_W  = 14;
  localparam int CMD_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_BUILD  = 3'd1,
    CMD_RD_OFF = 3'd2,
    CMD_RD_NB  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_VERT_ZERO = 3'd1,
    ST_VERT_HIGH = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_READ  = 3'd4
  } status_code_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_ZERO,
    S_EDGE_RD,
    S_EDGE_CAP,
    S_END_A,
    S_END_B,
    S_PFX_RD,
    S_PFX_WR,
    S_PFX_LAST,
    S_FINISH
  } state_t;

  // datapath step selected by the controller
  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_ACCEPT,
    STEP_RD_DONE,
    STEP_ZERO,
    STEP_EDGE_RD,
    STEP_EDGE_CAP,
    STEP_END_A,
    STEP_END_B,
    STEP_PFX_RD,
    STEP_PFX_WR,
    STEP_PFX_LAST,
    STEP_FINISH
  } step_t;

  typedef struct packed {
    step_t step;
    logic  scatter;   // edge walk after the prefix sweep: place neighbours
  } dp_cmd_t;

  typedef struct packed {
    logic read_ok;    // incoming read command is in range and graph built
    logic v_over;     // vertex counter past the live vertex count
    logic edge_end;   // edge counter reached the kept edge count
  } dp_stat_t;

endpackage

[hw/rtl/edge_list_to_csr_builder.sv]
// Add, clear and rejected commands give their result in the cycle after start and
//   take a new beat every cycle; reads pass a wait state and take no new beat until done.
// Build keeps busy high through a zeroing sweep, two walks over the kept edges that update
//   the degree RAM for both ends of each edge, and a prefix sweep over the live vertices.
// busy is high only during a build or an accepted read; results are one-cycle done strobes
//   that the receiver cannot stall. Sync reset: empty graph, vertex_count 1024.
module edge_list_to_csr_builder import elcb_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [VERTEX_W-1:0] vertex_a,
  input  logic [VERTEX_W-1:0] vertex_b,
  input  logic [INDEX_W-1:0]  read_index,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  value,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  dp_cmd_t             dp_cmd;
  dp_stat_t            stat;
  logic                cfg_we;
  logic [VERTEX_W-1:0] vertex_count;

  // config register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? 32'(vertex_count) : 32'd0;

  elcb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .stat(stat), .busy(busy), .dp_cmd(dp_cmd)
  );

  elcb_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst(rst), .dp_cmd(dp_cmd), .stat(stat),
    .cmd(cmd), .vertex_a(vertex_a), .vertex_b(vertex_b), .read_index(read_index),
    .cfg_we(cfg_we), .cfg_data(pwdata[VERTEX_W-1:0]), .vertex_count(vertex_count),
    .done(done), .status(status), .value(value)
  );

endmodule

[hw/rtl/elcb_ram.sv]
module elcb_ram import elcb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/elcb_ctrl.sv]
module elcb_ctrl import elcb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [CMD_W-1:0] cmd,
  input  dp_stat_t       stat,
  output logic           busy,
  output dp_cmd_t        dp_cmd
);

  state_t state, state_next;
  logic   scatter, scatter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      scatter <= 1'b0;
    end else begin
      state   <= state_next;
      scatter <= scatter_next;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    scatter_next = scatter;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_BUILD) begin
            state_next   = S_ZERO;
            scatter_next = 1'b0;
          end else if ((cmd == CMD_RD_OFF || cmd == CMD_RD_NB) && stat.read_ok) begin
            state_next = S_RD_WAIT;
          end
        end
      end
      S_RD_WAIT: state_next = S_IDLE;
      S_ZERO: begin
        if (stat.v_over) state_next = S_EDGE_RD;
      end
      S_EDGE_RD: begin
        if (!stat.edge_end)  state_next = S_EDGE_CAP;
        else if (scatter)    state_next = S_FINISH;
        else                 state_next = S_PFX_RD;
      end
      S_EDGE_CAP: state_next = S_END_A;
      S_END_A:    state_next = S_END_B;
      S_END_B:    state_next = S_EDGE_RD;
      S_PFX_RD: begin
        state_next = stat.v_over ? S_PFX_LAST : S_PFX_WR;
      end
      S_PFX_WR:   state_next = S_PFX_RD;
      S_PFX_LAST: begin
        state_next   = S_EDGE_RD;
        scatter_next = 1'b1;
      end
      S_FINISH:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy           = (state != S_IDLE);
    dp_cmd.scatter = scatter;
    unique case (state)
      S_IDLE:     dp_cmd.step = start ? STEP_ACCEPT : STEP_IDLE;
      S_RD_WAIT:  dp_cmd.step = STEP_RD_DONE;
      S_ZERO:     dp_cmd.step = STEP_ZERO;
      S_EDGE_RD:  dp_cmd.step = STEP_EDGE_RD;
      S_EDGE_CAP: dp_cmd.step = STEP_EDGE_CAP;
      S_END_A:    dp_cmd.step = STEP_END_A;
      S_END_B:    dp_cmd.step = STEP_END_B;
      S_PFX_RD:   dp_cmd.step = STEP_PFX_RD;
      S_PFX_WR:   dp_cmd.step = STEP_PFX_WR;
      S_PFX_LAST: dp_cmd.step = STEP_PFX_LAST;
      S_FINISH:   dp_cmd.step = STEP_FINISH;
      default:    dp_cmd.step = STEP_IDLE;
    endcase
  end

endmodule

[hw/rtl/elcb_dp.sv]
module elcb_dp import elcb_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             dp_cmd,
  output dp_stat_t            stat,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [VERTEX_W-1:0] vertex_a,
  input  logic [VERTEX_W-1:0] vertex_b,
  input  logic [INDEX_W-1:0]  read_index,
  input  logic                cfg_we,
  input  logic [VERTEX_W-1:0] cfg_data,
  output logic [VERTEX_W-1:0] vertex_count,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  value
);

  localparam int KW  = $clog2(MAX_EDGES + 1);
  localparam int OW  = $clog2(2 * MAX_EDGES + 1);
  localparam int VIW = $clog2(MAX_VERTICES + 2);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CAW = $clog2(MAX_VERTICES + 1);
  localparam int RAW = $clog2(MAX_VERTICES + 2);
  localparam int NAW = $clog2(2 * MAX_EDGES);
  localparam int CWA = (VIW > INDEX_W) ? VIW : INDEX_W;
  localparam int CW  = ((CWA > KW + 1) ? CWA : KW + 1) + 1;
  localparam int EDW = 2 * VERTEX_W;

  logic [KW-1:0]       kept;
  logic                built;
  logic [KW-1:0]       k;
  logic [VIW-1:0]      vidx;
  logic [OW-1:0]       sum;
  logic [VERTEX_W-1:0] ea, eb;
  logic                rd_off;

  // memory ports
  logic            edge_we;
  logic [EAW-1:0]  edge_waddr, edge_raddr;
  logic [EDW-1:0]  edge_wdata, edge_rdata;
  logic            cnt_we;
  logic [CAW-1:0]  cnt_waddr, cnt_raddr;
  logic [OW-1:0]   cnt_wdata, cnt_rdata;
  logic            row_we;
  logic [RAW-1:0]  row_waddr, row_raddr;
  logic [OW-1:0]   row_rdata;
  logic            nb_we;
  logic [NAW-1:0]  nb_waddr, nb_raddr;
  logic [VERTEX_W-1:0] nb_wdata, nb_rdata;

  // range checks
  logic [CW-1:0] vc_c, n_c, a_c, b_c, idx_c, vidx_c;
  logic          add_zero, add_high, add_self, add_full, add_store;
  logic          off_ok, nb_ok;

  always_comb begin
    vc_c   = CW'(vertex_count);
    n_c    = (vc_c > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_c;
    a_c    = CW'(vertex_a);
    b_c    = CW'(vertex_b);
    idx_c  = CW'(read_index);
    vidx_c = CW'(vidx);
    add_zero  = (vertex_a == '0) || (vertex_b == '0);
    add_high  = (a_c > n_c) || (b_c > n_c);
    add_self  = (vertex_a == vertex_b);
    add_full  = (kept == KW'(MAX_EDGES));
    add_store = !add_zero && !add_high && !add_self && !add_full;
    off_ok    = built && (idx_c != '0) && (idx_c <= n_c + CW'(1));
    nb_ok     = built && (idx_c < (CW'(kept) << 1));
    stat.read_ok  = (cmd == CMD_RD_OFF) ? off_ok : nb_ok;
    stat.v_over   = (vidx_c > n_c);
    stat.edge_end = (k == kept);
  end

  // memory port steering
  always_comb begin
    edge_we    = (dp_cmd.step == STEP_ACCEPT) && (cmd == CMD_ADD) && add_store;
    edge_waddr = EAW'(kept);
    edge_wdata = {vertex_a, vertex_b};
    edge_raddr = EAW'(k);

    cnt_we    = 1'b0;
    cnt_waddr = CAW'(vidx);
    cnt_wdata = '0;
    cnt_raddr = CAW'(vidx);
    row_we    = 1'b0;
    row_waddr = RAW'(vidx);
    row_raddr = RAW'(read_index);
    nb_we     = 1'b0;
    nb_waddr  = NAW'(cnt_rdata);
    nb_wdata  = eb;
    nb_raddr  = NAW'(read_index);
    unique case (dp_cmd.step)
      STEP_ZERO: cnt_we = !stat.v_over;
      STEP_EDGE_CAP: cnt_raddr = CAW'(edge_rdata[EDW-1:VERTEX_W]);
      STEP_END_A: begin
        cnt_we    = 1'b1;
        cnt_waddr = CAW'(ea);
        cnt_wdata = cnt_rdata + OW'(1);
        cnt_raddr = CAW'(eb);
        nb_we     = dp_cmd.scatter;
        nb_wdata  = eb;
      end
      STEP_END_B: begin
        cnt_we    = 1'b1;
        cnt_waddr = CAW'(eb);
        cnt_wdata = cnt_rdata + OW'(1);
        nb_we     = dp_cmd.scatter;
        nb_wdata  = ea;
      end
      STEP_PFX_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = sum;
        row_we    = 1'b1;
      end
      STEP_PFX_LAST: row_we = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_W'(1024);
      kept         <= '0;
      built        <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        vertex_count <= cfg_data;
        kept         <= '0;
        built        <= 1'b0;
      end
      unique case (dp_cmd.step)
        STEP_ACCEPT: begin
          if (cmd == CMD_BUILD) begin
            done <= 1'b0;
          end else if ((cmd == CMD_RD_OFF || cmd == CMD_RD_NB) && stat.read_ok) begin
            done <= 1'b0;
          end else begin
            done <= 1'b1;
          end
          if (cmd == CMD_ADD && add_store) begin
            kept  <= kept + KW'(1);
            built <= 1'b0;
          end
          if (cmd == CMD_CLEAR) begin
            kept  <= '0;
            built <= 1'b0;
          end
        end
        STEP_RD_DONE: done <= 1'b1;
        STEP_FINISH: begin
          built <= 1'b1;
          done  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // counters, edge latch and result payload
  always_ff @(posedge clk) begin
    unique case (dp_cmd.step)
      STEP_ACCEPT: begin
        vidx   <= VIW'(1);
        k      <= '0;
        rd_off <= (cmd == CMD_RD_OFF);
        status <= ST_OK;
        value  <= '0;
        unique case (cmd)
          CMD_ADD: begin
            if (add_zero)      status <= ST_VERT_ZERO;
            else if (add_high) status <= ST_VERT_HIGH;
            else if (!add_self && add_full) status <= ST_FULL;
            value <= add_store ? VALUE_W'(kept + KW'(1)) : VALUE_W'(kept);
          end
          CMD_BUILD, CMD_CLEAR: value <= '0;
          CMD_RD_OFF, CMD_RD_NB: begin
            if (!stat.read_ok) status <= ST_BAD_READ;
          end
          default: status <= ST_BAD_READ;
        endcase
      end
      STEP_RD_DONE: begin
        status <= ST_OK;
        value  <= rd_off ? VALUE_W'(row_rdata) : VALUE_W'(nb_rdata);
      end
      STEP_ZERO: begin
        if (!stat.v_over) vidx <= vidx + VIW'(1);
      end
      STEP_EDGE_RD: begin
        if (stat.edge_end && !dp_cmd.scatter) begin
          vidx <= VIW'(1);
          sum  <= '0;
        end
      end
      STEP_EDGE_CAP: begin
        ea <= edge_rdata[EDW-1:VERTEX_W];
        eb <= edge_rdata[VERTEX_W-1:0];
      end
      STEP_END_B: k <= k + KW'(1);
      STEP_PFX_WR: begin
        sum  <= sum + cnt_rdata;
        vidx <= vidx + VIW'(1);
      end
      STEP_PFX_LAST: k <= '0;
      STEP_FINISH: begin
        status <= ST_OK;
        value  <= VALUE_W'(kept);
      end
      default: ;
    endcase
  end

  elcb_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  // degree counts, reused as fill positions during the scatter walk
  elcb_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES + 1)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  elcb_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES + 2)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(sum),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  elcb_ram #(.WIDTH(VERTEX_W), .DEPTH(2 * MAX_EDGES)) u_nb_ram (
    .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

endmodule
